FILE: src/v3n_pkg.sv
// v3n_pkg: shared widths for the 3D vector normalise unit.
// No dependencies.
package v3n_pkg;
  localparam int COMP_W = 32;
  localparam int SQ_W   = 64;
  localparam int THR_W  = 16;
endpackage

FILE: src/vector3_normalize_unit.sv
// vector3_normalize_unit: fixed-point 3D vector normaliser, fully pipelined.
// Steps from start to done: magnitudes, squares, sum, square root, threshold, divide, output.
// Throughput: one request per cycle; busy is held low, the receiver cannot stall.
// One square-root step and one divide step per stage set the depth.
// Reset: synchronous rst clears valid bits and sets min_length to 1.
// Depends on v3n_pkg.
module vector3_normalize_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic signed [31:0] vec_x,
  input  logic signed [31:0] vec_y,
  input  logic signed [31:0] vec_z,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output logic        done,
  output logic signed [31:0] unit_x,
  output logic signed [31:0] unit_y,
  output logic signed [31:0] unit_z,
  output logic [31:0] length,
  output logic        small_flag
);
  localparam int W   = v3n_pkg::COMP_W;
  localparam int SW  = v3n_pkg::SQ_W;
  localparam int NS  = W;               // root bits
  localparam int QW  = W + FRAC_BITS;   // dividend / quotient bits
  localparam int NQ  = QW;

  logic [v3n_pkg::THR_W-1:0] min_length;
  always_ff @(posedge clk) begin
    if (rst) min_length <= 16'd1;
    else if (cfg_we) min_length <= cfg_wdata;
  end

  assign busy = 1'b0;
  logic accept;
  assign accept = start && !busy;

  // stage 0: magnitudes
  logic        v0;
  logic [31:0] a0 [3];
  logic [31:0] r0 [3];
  logic [2:0]  s0;
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else v0 <= accept;
    r0[0] <= vec_x; r0[1] <= vec_y; r0[2] <= vec_z;
    s0 <= {vec_z[31], vec_y[31], vec_x[31]};
    a0[0] <= vec_x[31] ? 32'(-vec_x) : vec_x;
    a0[1] <= vec_y[31] ? 32'(-vec_y) : vec_y;
    a0[2] <= vec_z[31] ? 32'(-vec_z) : vec_z;
  end

  // stage 1: squares
  logic        v1;
  logic [31:0] a1 [3];
  logic [31:0] r1 [3];
  logic [2:0]  s1;
  logic [SW-1:0] q1 [3];
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= v0;
    a1 <= a0; r1 <= r0; s1 <= s0;
    for (int i = 0; i < 3; i++) q1[i] <= SW'(a0[i]) * SW'(a0[i]);
  end

  // stage 2: sum (at most 3 * 2^62, fits 64 bits)
  logic        v2;
  logic [31:0] a2 [3];
  logic [31:0] r2 [3];
  logic [2:0]  s2;
  logic [SW-1:0] sum2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    a2 <= a1; r2 <= r1; s2 <= s1;
    sum2 <= q1[0] + q1[1] + q1[2];
  end

  // square root, one result bit per stage (restoring)
  logic           sv   [NS+1];
  logic [SW+1:0]  srem [NS+1];
  logic [SW+1:0]  srad [NS+1];
  logic [31:0]    sroot[NS+1];
  logic [31:0]    sa   [NS+1][3];
  logic [31:0]    sr   [NS+1][3];
  logic [2:0]     ss   [NS+1];
  always_comb begin
    sv[0] = v2; srem[0] = '0; srad[0] = {sum2, 2'b00}; sroot[0] = '0;
    sa[0] = a2; sr[0] = r2; ss[0] = s2;
  end
  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    logic [SW+1:0] rem_sh, trial;
    always_comb begin
      rem_sh = {srem[k][SW-1:0], srad[k][SW+1:SW]};
      trial  = {(SW+2-W-2)'(0), sroot[k], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else sv[k+1] <= sv[k];
      srad[k+1] <= {srad[k][SW-1:0], 2'b00};
      sa[k+1] <= sa[k]; sr[k+1] <= sr[k]; ss[k+1] <= ss[k];
      if (rem_sh >= trial) begin
        srem[k+1]  <= rem_sh - trial;
        sroot[k+1] <= {sroot[k][30:0], 1'b1};
      end else begin
        srem[k+1]  <= rem_sh;
        sroot[k+1] <= {sroot[k][30:0], 1'b0};
      end
    end
  end

  // threshold stage
  logic        v3, sm3;
  logic [31:0] len3;
  logic [31:0] a3 [3];
  logic [31:0] r3 [3];
  logic [2:0]  s3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= sv[NS];
    len3 <= sroot[NS]; a3 <= sa[NS]; r3 <= sr[NS]; s3 <= ss[NS];
    sm3 <= sroot[NS] <= 32'(min_length);
  end

  // three dividers, one quotient bit per stage (restoring)
  logic          dv  [NQ+1];
  logic          dsm [NQ+1];
  logic [31:0]   dlen[NQ+1];
  logic [31:0]   dr  [NQ+1][3];
  logic [2:0]    ds  [NQ+1];
  logic [QW-1:0] dn  [NQ+1][3];
  logic [32:0]   drem[NQ+1][3];
  always_comb begin
    dv[0] = v3; dsm[0] = sm3; dlen[0] = len3; dr[0] = r3; ds[0] = s3;
    for (int i = 0; i < 3; i++) begin
      dn[0][i]   = {a3[i], FRAC_BITS'(0)};
      drem[0][i] = '0;
    end
  end
  for (genvar k = 0; k < NQ; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else dv[k+1] <= dv[k];
      dsm[k+1] <= dsm[k]; dlen[k+1] <= dlen[k]; dr[k+1] <= dr[k]; ds[k+1] <= ds[k];
      for (int i = 0; i < 3; i++) begin
        logic [32:0] t;
        t = {drem[k][i][31:0], dn[k][i][QW-1]};
        if (t >= {1'b0, dlen[k]}) begin
          drem[k+1][i] <= t - {1'b0, dlen[k]};
          dn[k+1][i]   <= {dn[k][i][QW-2:0], 1'b1};
        end else begin
          drem[k+1][i] <= t;
          dn[k+1][i]   <= {dn[k][i][QW-2:0], 1'b0};
        end
      end
    end
  end

  // output stage
  logic [31:0] qv [3];
  always_comb begin
    for (int i = 0; i < 3; i++)
      qv[i] = ds[NQ][i] ? 32'(-dn[NQ][i][31:0]) : dn[NQ][i][31:0];
  end
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv[NQ];
    length     <= dlen[NQ];
    small_flag <= dsm[NQ];
    unit_x <= dsm[NQ] ? dr[NQ][0] : qv[0];
    unit_y <= dsm[NQ] ? dr[NQ][1] : qv[1];
    unit_z <= dsm[NQ] ? dr[NQ][2] : qv[2];
  end

`ifndef SYNTH
  a_lat: assert property (@(posedge clk) disable iff (rst)
    sv[NS] |-> ##(NQ+2) done) else $error("done lost");
  a_small: assert property (@(posedge clk) disable iff (rst)
    done && !small_flag |-> length != 32'd0) else $error("divide by zero");
  a_gap: assert property (@(posedge clk) disable iff (rst)
    v3 |=> dv[1]) else $error("valid dropped");
`endif
endmodule

FILE: sim/vector3_normalize_unit_tb.sv
// Testbench for vector3_normalize_unit: directed table, threshold cases, then random vectors,
// each result checked against its table entry or a behavioural normaliser. Depends on v3n_pkg.
module vector3_normalize_unit_tb;

  localparam int FRAC_BITS = 16;
  localparam int LATENCY   = 1 + 2 + 32 + 1 + (32 + FRAC_BITS) + 1;
  localparam int N_RANDOM  = 650;

  typedef struct packed {
    logic [v3n_pkg::COMP_W-1:0] ux;
    logic [v3n_pkg::COMP_W-1:0] uy;
    logic [v3n_pkg::COMP_W-1:0] uz;
    logic [31:0]       len;
    logic              tiny;
  } norm_res_t;

  typedef struct {
    logic [v3n_pkg::COMP_W-1:0] x, y, z;
    bit                known;
    norm_res_t         res;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic cfg_we = 1'b0;
  logic [v3n_pkg::THR_W-1:0] cfg_wdata = '0;
  logic done;
  logic signed [31:0] unit_x, unit_y, unit_z;
  logic [31:0] length;
  logic small_flag;

  logic [v3n_pkg::THR_W-1:0] thr_model;
  norm_res_t        norm_q[$];
  int               err_cnt = 0;
  int               send_idle = 0;

  vector3_normalize_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
    .length(length), .small_flag(small_flag)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [63:0] root_floor(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(input logic [31:0] v);
    return v[31] ? 64'(-$signed({32'hFFFF_FFFF, v})) : {32'd0, v};
  endfunction

  function automatic logic [31:0] comp_div(input logic [31:0] c, input logic [31:0] len);
    logic [63:0] q;
    q = (mag(c) << FRAC_BITS) / {32'd0, len};
    if (c[31]) q = -q;
    return q[31:0];
  endfunction

  function automatic norm_res_t normalise(input logic [31:0] x, y, z);
    norm_res_t r;
    logic [63:0] ax, ay, az, len;
    ax = mag(x); ay = mag(y); az = mag(z);
    len = root_floor(ax * ax + ay * ay + az * az);
    r.len = len[31:0];
    if (r.len <= {16'd0, thr_model}) begin
      r.ux = x; r.uy = y; r.uz = z; r.tiny = 1'b1;
    end else begin
      r.ux = comp_div(x, r.len);
      r.uy = comp_div(y, r.len);
      r.uz = comp_div(z, r.len);
      r.tiny = 1'b0;
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    norm_res_t want, got;
    if (!rst && done) begin
      got = {unit_x, unit_y, unit_z, length, small_flag};
      if (norm_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        err_cnt++;
      end else begin
        want = norm_q.pop_front();
        if (want.ux !== got.ux) begin
          $display("%0t: unit_x exp %h got %h", $time, want.ux, got.ux); err_cnt++;
        end
        if (want.uy !== got.uy) begin
          $display("%0t: unit_y exp %h got %h", $time, want.uy, got.uy); err_cnt++;
        end
        if (want.uz !== got.uz) begin
          $display("%0t: unit_z exp %h got %h", $time, want.uz, got.uz); err_cnt++;
        end
        if (want.len !== got.len) begin
          $display("%0t: length exp %h got %h", $time, want.len, got.len); err_cnt++;
        end
        if (want.tiny !== got.tiny) begin
          $display("%0t: small_flag exp %b got %b", $time, want.tiny, got.tiny);
          err_cnt++;
        end
      end
    end
  end

  task automatic send_vec(input logic [31:0] x, y, z, input bit known, input norm_res_t res);
    while ($urandom_range(99) < send_idle) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    vec_x <= x; vec_y <= y; vec_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    norm_q.push_back(known ? res : normalise(x, y, z));
    @(negedge clk);
  endtask

  task automatic drain_and_cfg(input logic [v3n_pkg::THR_W-1:0] thr);
    start <= 1'b0;
    while (norm_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= thr;
    @(negedge clk);
    cfg_we <= 1'b0;
    thr_model = thr;
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(5))
      0: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      1: return 32'($signed($urandom_range(8)) - 4);
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    vec_row_t dir_tab[13];
    norm_res_t none;
    logic [31:0] x, y, z;
    none = '0;
    thr_model = 16'd1;
    dir_tab = '{
      '{32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1}},
      '{32'h1, 32'h0, 32'h0, 1, '{32'h1, 32'h0, 32'h0, 32'h1, 1'b1}},
      '{32'h0001_0000, 32'h0, 32'h0, 1,
        '{32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0}},
      '{32'h0, 32'hFFFF_0000, 32'h0, 1,
        '{32'h0, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 1'b0}},
      '{32'h8000_0000, 32'h0, 32'h0, 1,
        '{32'hFFFF_0000, 32'h0, 32'h0, 32'h8000_0000, 1'b0}},
      '{32'h7FFF_FFFF, 32'h0, 32'h0, 0, none},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, none},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, none},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, none},
      '{32'h2, 32'h2, 32'hFFFF_FFFE, 0, none},
      '{32'h0003_0000, 32'h0004_0000, 32'h0, 0, none},
      '{32'hFFFF_FFFF, 32'h1, 32'h1, 0, none},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 0, none}
    };
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_tab[i])
      send_vec(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].known, dir_tab[i].res);
    // threshold extremes and mid values
    drain_and_cfg(16'hFFFF);
    send_vec(32'h0000_FFFF, 32'h0, 32'h0, 1,
             '{32'h0000_FFFF, 32'h0, 32'h0, 32'h0000_FFFF, 1'b1});
    send_vec(32'h0001_0000, 32'h0, 32'h0, 0, none);
    drain_and_cfg(16'h0000);
    send_vec(32'h1, 32'h0, 32'h0, 1, '{32'h0001_0000, 32'h0, 32'h0, 32'h1, 1'b0});
    send_vec(32'h0, 32'h0, 32'h0, 0, none);
    for (int ph = 0; ph < 3; ph++) begin
      drain_and_cfg(ph == 0 ? 16'h1234 : ph == 1 ? 16'h00FF : 16'hA5C3);
      send_idle = ph == 0 ? 33 : ph == 1 ? 87 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) begin
        x = rand_comp(); y = rand_comp(); z = rand_comp();
        send_vec(x, y, z, 0, none);
      end
    end
    start <= 1'b0;
    fork
      begin
        while (norm_q.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
      end
      begin
        repeat (20 * LATENCY + 1000) @(negedge clk);
      end
    join_any
    if (err_cnt == 0 && norm_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: files.f
src/v3n_pkg.sv
src/vector3_normalize_unit.sv
sim/vector3_normalize_unit_tb.sv
